>>> design/assert_macros.svh
// Assertion macros for the waypoint spot-turn controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Antecedent and consequent in the same cycle.
`define WSTC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Consequent in the cycle after the antecedent.
`define WSTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define WSTC_ASSERT_NOW(label, clk, rst, ante, cons)
`define WSTC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> design/wstc_pkg.sv
// Shared types, constants and tables of the waypoint spot-turn controller.
package wstc_pkg;

  localparam int MAX_WAYPOINTS_DEF = 64;
  localparam int POSITION_BITS_DEF = 24;
  localparam int ANGLE_FRACTION_BITS = 13;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  localparam logic [1:0] REG_LINEAR_LIMIT  = 2'd0;
  localparam logic [1:0] REG_ANGULAR_LIMIT = 2'd1;
  localparam logic [1:0] REG_POS_TOL       = 2'd2;
  localparam logic [1:0] REG_HEAD_TOL      = 2'd3;

  localparam logic [15:0] LINEAR_LIMIT_RST  = 16'd901;
  localparam logic [14:0] ANGULAR_LIMIT_RST = 15'd20480;
  localparam logic [15:0] POS_TOL_RST       = 16'd41;
  localparam logic [14:0] HEAD_TOL_RST      = 15'd82;

  localparam longint PI_Q30 = 64'sd3373259426;
  localparam int ANG_SHIFT = 30 - ANGLE_FRACTION_BITS;
  localparam longint PI_ANG = (PI_Q30 + (64'sd1 <<< (ANG_SHIFT - 1))) >>> ANG_SHIFT;
  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS = 19;
  localparam logic [17:0] DIST_SAT = 18'd131072;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIFF,
    ST_SQUARE,
    ST_NORM,
    ST_ROTATE,
    ST_ROUND,
    ST_THETA,
    ST_PUT
  } state_t;

  typedef struct packed {
    logic latch;
    logic diff;
    logic square;
    logic norm_step;
    logic rot_init;
    logic rot_step;
    logic round;
    logic theta;
    logic put;
  } ctl_cmd_t;

  typedef struct packed {
    logic tick_go;
    logic norm_done;
    logic rot_last;
    logic out_free;
  } dp_status_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    unique case (i)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837830;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      5'd24: v = 30'd64;
      5'd25: v = 30'd32;
      5'd26: v = 30'd16;
      5'd27: v = 30'd8;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

>>> design/wstc_ctrl.sv
// Sequencer of the waypoint spot-turn controller.
module wstc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  wstc_pkg::dp_status_t  status,
  output wstc_pkg::ctl_cmd_t    cmd
);

  wstc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wstc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      wstc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_next = wstc_pkg::ST_DECODE;
        end
      end
      wstc_pkg::ST_DECODE: begin
        state_next = status.tick_go ? wstc_pkg::ST_DIFF : wstc_pkg::ST_PUT;
      end
      wstc_pkg::ST_DIFF: begin
        cmd.diff = 1'b1;
        state_next = wstc_pkg::ST_SQUARE;
      end
      wstc_pkg::ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = wstc_pkg::ST_NORM;
      end
      wstc_pkg::ST_NORM: begin
        if (status.norm_done) begin
          cmd.rot_init = 1'b1;
          state_next = wstc_pkg::ST_ROTATE;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      wstc_pkg::ST_ROTATE: begin
        cmd.rot_step = 1'b1;
        if (status.rot_last) state_next = wstc_pkg::ST_ROUND;
      end
      wstc_pkg::ST_ROUND: begin
        cmd.round = 1'b1;
        state_next = wstc_pkg::ST_THETA;
      end
      wstc_pkg::ST_THETA: begin
        cmd.theta = 1'b1;
        state_next = wstc_pkg::ST_PUT;
      end
      wstc_pkg::ST_PUT: begin
        // hold until the output register can take the transfer
        if (status.out_free) begin
          cmd.put = 1'b1;
          state_next = wstc_pkg::ST_IDLE;
        end
      end
      default: state_next = wstc_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> design/wstc_datapath.sv
// Datapath of the waypoint spot-turn controller: table, CORDIC, square root, commands.
module wstc_datapath #(
  parameter int MAX_WAYPOINTS = wstc_pkg::MAX_WAYPOINTS_DEF,
  parameter int POSITION_BITS = wstc_pkg::POSITION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [15:0]                     cfg_data,
  input  logic [1:0]                      func,
  input  logic signed [POSITION_BITS-1:0] pos_x,
  input  logic signed [POSITION_BITS-1:0] pos_y,
  input  logic signed [15:0]              heading,
  input  logic [6:0]                      slot,
  input  wstc_pkg::ctl_cmd_t              cmd,
  output wstc_pkg::dp_status_t            status,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [15:0]                     linear_speed,
  output logic signed [15:0]              turn_rate,
  output logic                            cmd_valid,
  output logic                            arrived,
  output logic                            goal_reached,
  output logic [6:0]                      current_index
);

  localparam int PB  = POSITION_BITS;
  localparam int AW  = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam int IXW = (AW > 7) ? AW : 7;
  localparam int CW  = 14;
  localparam int MW  = 2 * PB + 16;
  localparam int NW  = (PB + 1 > 31) ? PB + 1 : 31;
  localparam int BW  = wstc_pkg::ANGLE_FRACTION_BITS + 3;
  localparam int TW  = ((BW > 17) ? BW : 17) + 2;
  localparam int SH  = wstc_pkg::ANG_SHIFT;

  // configuration
  logic [15:0] linear_limit;
  logic [14:0] angular_limit;
  logic [15:0] position_tolerance;
  logic [14:0] heading_tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      linear_limit       <= wstc_pkg::LINEAR_LIMIT_RST;
      angular_limit      <= wstc_pkg::ANGULAR_LIMIT_RST;
      position_tolerance <= wstc_pkg::POS_TOL_RST;
      heading_tolerance  <= wstc_pkg::HEAD_TOL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wstc_pkg::REG_LINEAR_LIMIT:  linear_limit       <= cfg_data;
        wstc_pkg::REG_ANGULAR_LIMIT: angular_limit      <= cfg_data[14:0];
        wstc_pkg::REG_POS_TOL:       position_tolerance <= cfg_data;
        wstc_pkg::REG_HEAD_TOL:      heading_tolerance  <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // latched item
  logic [1:0]              func_r;
  logic signed [PB-1:0]    px_r, py_r;
  logic signed [15:0]      yaw_r;
  logic [6:0]              slot_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r <= func;
      px_r   <= pos_x;
      py_r   <= pos_y;
      yaw_r  <= heading;
      slot_r <= slot;
    end
  end

  // path state
  logic [6:0] path_length, waypoint_index;
  logic       at_position, goal_flag;

  logic [IXW-1:0] idx_w, slot_w;
  logic [AW-1:0]  raddr, waddr;
  logic           slot_ok, active;

  assign idx_w   = IXW'(waypoint_index);
  assign slot_w  = IXW'(slot_r);
  assign raddr   = idx_w[AW-1:0];
  assign waddr   = slot_w[AW-1:0];
  assign slot_ok = CW'(slot_r) < CW'(MAX_WAYPOINTS);
  assign active  = (waypoint_index < path_length) &&
                   (CW'(waypoint_index) < CW'(MAX_WAYPOINTS));

  // waypoint table
  logic [MW-1:0] wp_mem [MAX_WAYPOINTS];
  logic [MW-1:0] rdata;

  always_ff @(posedge clk) begin
    if (cmd.put && func_r == wstc_pkg::FUNC_WRITE && slot_ok) begin
      wp_mem[waddr] <= {px_r, py_r, yaw_r};
    end
    rdata <= wp_mem[raddr];
  end

  logic signed [PB-1:0] wx, wy;
  logic signed [15:0]   wyaw;
  assign wx   = rdata[MW-1 -: PB];
  assign wy   = rdata[MW-PB-1 -: PB];
  assign wyaw = rdata[15:0];

  // differences
  logic signed [PB:0] dx, dy;
  logic [PB:0]        ax, ay;
  logic               dx_neg, dy_neg, sat;

  assign dx = (PB+1)'(wx) - (PB+1)'(px_r);
  assign dy = (PB+1)'(wy) - (PB+1)'(py_r);

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      dx_neg <= dx[PB];
      dy_neg <= dy[PB];
      ax     <= dx[PB] ? (PB+1)'(-dx) : (PB+1)'(dx);
      ay     <= dy[PB] ? (PB+1)'(-dy) : (PB+1)'(dy);
    end
  end

  // squares and normalisation
  logic [33:0]   sqx, sqy;
  logic [NW-1:0] nx, ny, nm;
  logic          zero;

  assign nm = (nx > ny) ? nx : ny;
  assign status.norm_done = zero ||
    ((nm >= (NW'(1) << 29)) && (nm < (NW'(1) << 30)));

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      sqx  <= 34'(ax[16:0]) * 34'(ax[16:0]);
      sqy  <= 34'(ay[16:0]) * 34'(ay[16:0]);
      sat  <= (ax > (PB+1)'(131071)) || (ay > (PB+1)'(131071));
      nx   <= NW'(ax);
      ny   <= NW'(ay);
      zero <= (ax == '0) && (ay == '0);
    end else if (cmd.norm_step) begin
      priority if (nm >= (NW'(1) << 30)) begin
        nx <= nx >> 1;
        ny <= ny >> 1;
      end else if (nm < (NW'(1) << 26)) begin
        nx <= nx << 4;
        ny <= ny << 4;
      end else begin
        nx <= nx << 1;
        ny <= ny << 1;
      end
    end
  end

  // CORDIC vectoring and bit-pair square root, sharing one step counter
  logic signed [32:0] cx, cy;
  logic signed [33:0] cz;
  logic [4:0]         it;
  logic [36:0]        rem, root, sq_b;
  logic [29:0]        atan_v;

  assign atan_v = wstc_pkg::atan_q30(it);
  assign status.rot_last = (it == 5'(wstc_pkg::CORDIC_STEPS - 1));
  assign sq_b = 37'(1) << (6'd36 - {it, 1'b0});

  always_ff @(posedge clk) begin
    if (cmd.rot_init) begin
      cx   <= 33'(nx[29:0]);
      cy   <= 33'(ny[29:0]);
      cz   <= '0;
      it   <= '0;
      rem  <= 37'(sqx) + 37'(sqy);
      root <= '0;
    end else if (cmd.rot_step) begin
      if (!cy[32]) begin
        cx <= cx + (cy >>> it);
        cy <= cy - (cx >>> it);
        cz <= cz + 34'(atan_v);
      end else begin
        cx <= cx - (cy >>> it);
        cy <= cy + (cx >>> it);
        cz <= cz - 34'(atan_v);
      end
      if (it < 5'(wstc_pkg::SQRT_STEPS)) begin
        if (rem >= root + sq_b) begin
          rem  <= rem - (root + sq_b);
          root <= (root >> 1) + sq_b;
        end else begin
          root <= root >> 1;
        end
      end
      it <= it + 5'd1;
    end
  end

  // quadrant fix and rounding
  logic signed [33:0]   zq, zs, zr;
  logic signed [BW-1:0] bear;
  logic [17:0]          span;

  assign zq = dx_neg ? (34'(wstc_pkg::PI_Q30) - cz) : cz;
  assign zs = dy_neg ? -zq : zq;
  assign zr = zs[33] ? -((-zs + (34'sd1 <<< (SH - 1))) >>> SH)
                     : ((zs + (34'sd1 <<< (SH - 1))) >>> SH);

  always_ff @(posedge clk) begin
    if (cmd.round) begin
      bear <= zero ? '0 : BW'(zr);
      span <= sat ? wstc_pkg::DIST_SAT : root[17:0];
    end
  end

  // heading error, wrapped once
  logic signed [TW-1:0] th_raw, theta;
  localparam logic signed [TW-1:0] PI_T = TW'(wstc_pkg::PI_ANG);

  assign th_raw = TW'(bear) - TW'(yaw_r);

  always_ff @(posedge clk) begin
    if (cmd.theta) begin
      priority if (th_raw > PI_T) theta <= th_raw - (PI_T <<< 1);
      else if (th_raw < -PI_T)    theta <= th_raw + (PI_T <<< 1);
      else                        theta <= th_raw;
    end
  end

  // commands
  logic [TW-1:0]        th_abs, yd_abs, htol_w;
  logic signed [TW-1:0] yd, t_sel, alim_w;
  logic signed [15:0]   ang;
  logic [15:0]          lin;
  logic [17:0]          dd;
  logic                 at_new, adv;

  assign htol_w = TW'(heading_tolerance);
  assign alim_w = TW'(angular_limit);
  assign th_abs = theta[TW-1] ? TW'(-theta) : TW'(theta);
  assign yd     = TW'(wyaw) - TW'(yaw_r);
  assign yd_abs = yd[TW-1] ? TW'(-yd) : TW'(yd);

  always_comb begin
    if (at_position) t_sel = (yd_abs <= htol_w) ? '0 : yd;
    else             t_sel = (th_abs <= htol_w) ? '0 : theta;
    priority if (t_sel > alim_w) ang = 16'(alim_w);
    else if (t_sel < -alim_w)    ang = 16'(-alim_w);
    else                         ang = 16'(t_sel);
  end

  assign at_new = at_position || (span <= 18'(position_tolerance));
  assign dd     = (span <= 18'(position_tolerance)) ? '0 : span;
  assign lin    = (th_abs < htol_w) ? ((dd > 18'(linear_limit)) ? linear_limit : dd[15:0])
                                    : 16'd0;
  assign adv    = (ang == 16'sd0) && (lin == 16'd0) && at_new;

  // next path state
  logic [6:0] len_next, idx_next;
  logic       atp_next, goal_next, tick_go;

  assign tick_go = (func_r == wstc_pkg::FUNC_TICK) && active;
  assign status.tick_go = tick_go;

  always_comb begin
    len_next  = path_length;
    idx_next  = waypoint_index;
    atp_next  = at_position;
    goal_next = goal_flag;
    if (func_r == wstc_pkg::FUNC_START) begin
      len_next  = (CW'(slot_r) > CW'(MAX_WAYPOINTS)) ? 7'(MAX_WAYPOINTS) : slot_r;
      idx_next  = '0;
      atp_next  = 1'b0;
      goal_next = 1'b0;
    end else if (tick_go) begin
      if (adv) begin
        idx_next = waypoint_index + 7'd1;
        atp_next = 1'b0;
        if (idx_next == path_length) goal_next = 1'b1;
      end else begin
        atp_next = at_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      path_length    <= '0;
      waypoint_index <= '0;
      at_position    <= 1'b0;
      goal_flag      <= 1'b0;
    end else if (cmd.put) begin
      path_length    <= len_next;
      waypoint_index <= idx_next;
      at_position    <= atp_next;
      goal_flag      <= goal_next;
    end
  end

  // output register
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.put) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put) begin
      linear_speed  <= tick_go ? lin : 16'd0;
      turn_rate     <= tick_go ? ang : 16'sd0;
      cmd_valid     <= tick_go;
      arrived       <= tick_go ? at_new : atp_next;
      goal_reached  <= goal_next;
      current_index <= idx_next;
    end
  end

endmodule

>>> design/waypoint_spot_turn_controller_unit.sv
// Top level of the waypoint spot-turn controller.
// One item is in work at a time. A control tick passes from one input
// transfer to the next through fetch and square (idle, decode, difference,
// square), normalisation (up to eight shift steps and the step that starts the
// CORDIC), 30 CORDIC steps (the square root runs alongside in the first 19)
// and the finish (round, theta, put); the shared CORDIC step counter ends the
// rotation. Waypoint writes, path starts, ticks on a finished path and other
// codes go from decode straight to put. The put state holds while the output
// register is full and stalled. A new item is taken while the previous result
// still waits in the output register.
`include "assert_macros.svh"
module waypoint_spot_turn_controller_unit #(
  parameter int MAX_WAYPOINTS = wstc_pkg::MAX_WAYPOINTS_DEF,
  parameter int POSITION_BITS = wstc_pkg::POSITION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [15:0]                     cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      func,
  input  logic signed [POSITION_BITS-1:0] pos_x,
  input  logic signed [POSITION_BITS-1:0] pos_y,
  input  logic signed [15:0]              heading,
  input  logic [6:0]                      slot,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [15:0]                     linear_speed,
  output logic signed [15:0]              turn_rate,
  output logic                            cmd_valid,
  output logic                            arrived,
  output logic                            goal_reached,
  output logic [6:0]                      current_index
);

  wstc_pkg::ctl_cmd_t   cmd;
  wstc_pkg::dp_status_t status;

  wstc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  wstc_datapath #(
    .MAX_WAYPOINTS (MAX_WAYPOINTS),
    .POSITION_BITS (POSITION_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .func          (func),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .heading       (heading),
    .slot          (slot),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .linear_speed  (linear_speed),
    .turn_rate     (turn_rate),
    .cmd_valid     (cmd_valid),
    .arrived       (arrived),
    .goal_reached  (goal_reached),
    .current_index (current_index)
  );

  `WSTC_ASSERT_NOW(a_put_free, clk, rst, cmd.put, status.out_free)
  `WSTC_ASSERT_NEXT(a_one_item, clk, rst, in_valid && !in_stall, in_stall)
  `WSTC_ASSERT_NOW(a_rot_after_norm, clk, rst, cmd.rot_init, status.norm_done)
  `WSTC_ASSERT_NEXT(a_put_shows, clk, rst, cmd.put, out_valid)

endmodule
